// ----- hdl/mtt_pkg.sv -----
package mtt_pkg;

    localparam int NUM_SYMS    = 36;
    localparam int MAX_SYMS    = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_Z     = 8'h5A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [5:0] IDX_FIRST_DIGIT = 6'd26;
    localparam logic [5:0] IDX_ZERO        = 6'd35;

    // Each entry is {length, symbols}; symbol k is bit k, a dash is 1.
    localparam logic [7:0] CODE_TABLE [NUM_SYMS] = '{
        {3'd2, 5'd2},  {3'd4, 5'd1},  {3'd4, 5'd5},  {3'd3, 5'd1},  {3'd1, 5'd0},
        {3'd4, 5'd4},  {3'd3, 5'd3},  {3'd4, 5'd0},  {3'd2, 5'd0},  {3'd4, 5'd14},
        {3'd3, 5'd5},  {3'd4, 5'd2},  {3'd2, 5'd3},  {3'd2, 5'd1},  {3'd3, 5'd7},
        {3'd4, 5'd6},  {3'd4, 5'd11}, {3'd3, 5'd2},  {3'd3, 5'd0},  {3'd1, 5'd1},
        {3'd3, 5'd4},  {3'd4, 5'd8},  {3'd3, 5'd6},  {3'd4, 5'd9},  {3'd4, 5'd13},
        {3'd4, 5'd3},
        {3'd5, 5'd30}, {3'd5, 5'd28}, {3'd5, 5'd24}, {3'd5, 5'd16}, {3'd5, 5'd0},
        {3'd5, 5'd1},  {3'd5, 5'd3},  {3'd5, 5'd7},  {3'd5, 5'd15}, {3'd5, 5'd31}
    };

    typedef struct packed {
        logic [4:0] sym_bits;
        logic [2:0] sym_len;
        logic       has_char;
        logic [7:0] ch;
        logic       has_space;
        logic       has_nl;
    } t_job;

    typedef struct packed {
        logic       found;
        logic [7:0] ch;
    } t_match;

    function automatic logic [7:0] index_to_char(input logic [5:0] idx);
        logic [7:0] ch;
        if (idx < IDX_FIRST_DIGIT) begin
            ch = CH_A + {2'b00, idx};
        end else if (idx < IDX_ZERO) begin
            ch = CH_ONE + {2'b00, idx - IDX_FIRST_DIGIT};
        end else begin
            ch = CH_ZERO;
        end
        return ch;
    endfunction

    function automatic t_match code_to_char(input logic [2:0] len, input logic [4:0] bits);
        t_match m;
        m = '0;
        for (int i = 0; i < NUM_SYMS; i++) begin
            if (CODE_TABLE[i] == {len, bits}) begin
                m.found = 1'b1;
                m.ch    = index_to_char(6'(i));
            end
        end
        return m;
    endfunction

endpackage

// ----- hdl/mtt_if.sv -----
interface mtt_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    modport source (output valid, output text_byte, input ready);
    modport sink (input valid, input text_byte, output ready);
endinterface

interface mtt_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last;
    modport source (output valid, output out_byte, output last, input ready);
    modport sink (input valid, input out_byte, input last, output ready);
endinterface

interface mtt_cfg_if;
    logic valid;
    logic ready;
    logic mode;
    modport source (output valid, output mode, input ready);
    modport sink (input valid, input mode, output ready);
endinterface

// ----- hdl/mtt_front.sv -----
module mtt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_mode,
    input  logic          i_full,
    mtt_text_if.sink      i_in,
    output logic          o_push,
    output mtt_pkg::t_job o_job
);

    logic [4:0] r_bits, n_bits;
    logic [2:0] r_len, n_len;
    logic       r_bad, n_bad;

    logic          w_acc;
    logic [7:0]    w_c;
    logic [5:0]    w_idx;
    logic          w_enc_hit;
    logic [7:0]    w_entry;
    mtt_pkg::t_match w_match;
    mtt_pkg::t_job   w_job;

    assign i_in.ready = !i_full;
    assign w_acc      = i_in.valid && !i_full;
    assign w_c        = i_in.text_byte;
    assign w_match    = mtt_pkg::code_to_char(r_len, r_bits);

    always_comb begin
        w_idx     = '0;
        w_enc_hit = 1'b0;
        if (w_c inside {[mtt_pkg::CH_A:mtt_pkg::CH_Z]}) begin
            w_idx     = 6'(w_c - mtt_pkg::CH_A);
            w_enc_hit = 1'b1;
        end else if (w_c inside {[mtt_pkg::CH_ONE:mtt_pkg::CH_NINE]}) begin
            w_idx     = mtt_pkg::IDX_FIRST_DIGIT + 6'(w_c - mtt_pkg::CH_ONE);
            w_enc_hit = 1'b1;
        end else if (w_c == mtt_pkg::CH_ZERO) begin
            w_idx     = mtt_pkg::IDX_ZERO;
            w_enc_hit = 1'b1;
        end
        w_entry = mtt_pkg::CODE_TABLE[w_idx];
    end

    always_comb begin
        w_job  = '0;
        n_bits = r_bits;
        n_len  = r_len;
        n_bad  = r_bad;
        if (!i_mode) begin
            if (w_enc_hit) begin
                w_job.sym_bits  = w_entry[4:0];
                w_job.sym_len   = w_entry[7:5];
                w_job.has_space = 1'b1;
            end else if (w_c == mtt_pkg::CH_NL) begin
                w_job.has_nl = 1'b1;
            end
        end else begin
            if (w_c == mtt_pkg::CH_DOT || w_c == mtt_pkg::CH_DASH) begin
                if (r_len >= 3'(mtt_pkg::MAX_SYMS)) begin
                    n_bad = 1'b1;
                end else begin
                    if (w_c == mtt_pkg::CH_DASH) begin
                        n_bits = r_bits | (5'd1 << r_len);
                    end
                    n_len = r_len + 3'd1;
                end
            end else if (w_c inside {mtt_pkg::CH_SPACE, mtt_pkg::CH_TAB, mtt_pkg::CH_NL}) begin
                if (!r_bad && r_len != 3'd0 && w_match.found) begin
                    w_job.has_char  = 1'b1;
                    w_job.ch        = w_match.ch;
                    w_job.has_space = 1'b1;
                end
                w_job.has_nl = (w_c == mtt_pkg::CH_NL);
                n_bits = '0;
                n_len  = '0;
                n_bad  = 1'b0;
            end else begin
                n_bad = 1'b1;
            end
        end
    end

    assign o_job  = w_job;
    assign o_push = w_acc && (w_job.sym_len != 3'd0 || w_job.has_char
                              || w_job.has_space || w_job.has_nl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bits <= '0;
            r_len  <= '0;
            r_bad  <= 1'b0;
        end else if (w_acc) begin
            r_bits <= n_bits;
            r_len  <= n_len;
            r_bad  <= n_bad;
        end
    end

endmodule

// ----- hdl/mtt_queue.sv -----
module mtt_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtt_pkg::t_job i_job,
    input  logic          i_pop,
    output mtt_pkg::t_job o_job,
    output logic          o_empty,
    output logic          o_full
);

    localparam int PTR_W = $clog2(mtt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(mtt_pkg::QUEUE_DEPTH + 1);

    mtt_pkg::t_job    r_mem [mtt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == CNT_W'(mtt_pkg::QUEUE_DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- hdl/mtt_back.sv -----
module mtt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mtt_pkg::t_job i_job,
    input  logic          i_empty,
    output logic          o_pop,
    mtt_sym_if.source     o_out
);

    logic       r_act, n_act;
    logic [4:0] r_bits, n_bits;
    logic [2:0] r_len, n_len;
    logic       r_hc, n_hc;
    logic [7:0] r_ch, n_ch;
    logic       r_sp, n_sp;
    logic       r_nl, n_nl;
    logic       r_ov, n_ov;
    logic [7:0] r_ob, n_ob;
    logic       r_ol, n_ol;

    logic       w_sym;
    logic [7:0] w_byte;
    logic [2:0] w_flags_after;
    logic       w_last;
    logic       w_load;
    logic       w_pop;

    always_comb begin
        w_sym = (r_len != 3'd0);
        if (w_sym) begin
            w_byte        = r_bits[0] ? mtt_pkg::CH_DASH : mtt_pkg::CH_DOT;
            w_flags_after = {r_hc, r_sp, r_nl};
        end else if (r_hc) begin
            w_byte        = r_ch;
            w_flags_after = {1'b0, r_sp, r_nl};
        end else if (r_sp) begin
            w_byte        = mtt_pkg::CH_SPACE;
            w_flags_after = {2'b00, r_nl};
        end else begin
            w_byte        = mtt_pkg::CH_NL;
            w_flags_after = 3'b000;
        end
        w_last = (!w_sym || r_len == 3'd1) && (w_flags_after == 3'b000);
        w_load = r_act && (!r_ov || o_out.ready);
        w_pop  = !i_empty && (!r_act || (w_load && w_last));
    end

    always_comb begin
        n_act  = r_act;
        n_bits = r_bits;
        n_len  = r_len;
        n_hc   = r_hc;
        n_ch   = r_ch;
        n_sp   = r_sp;
        n_nl   = r_nl;
        n_ov   = r_ov;
        n_ob   = r_ob;
        n_ol   = r_ol;
        if (w_load) begin
            n_ov = 1'b1;
            n_ob = w_byte;
            n_ol = w_last;
            if (w_sym) begin
                n_bits = r_bits >> 1;
                n_len  = r_len - 3'd1;
            end else begin
                {n_hc, n_sp, n_nl} = w_flags_after;
            end
            if (w_last) begin
                n_act = 1'b0;
            end
        end else if (o_out.ready) begin
            n_ov = 1'b0;
        end
        if (w_pop) begin
            n_act  = 1'b1;
            n_bits = i_job.sym_bits;
            n_len  = i_job.sym_len;
            n_hc   = i_job.has_char;
            n_ch   = i_job.ch;
            n_sp   = i_job.has_space;
            n_nl   = i_job.has_nl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_ov  <= 1'b0;
        end else begin
            r_act <= n_act;
            r_ov  <= n_ov;
        end
        r_bits <= n_bits;
        r_len  <= n_len;
        r_hc   <= n_hc;
        r_ch   <= n_ch;
        r_sp   <= n_sp;
        r_nl   <= n_nl;
        r_ob   <= n_ob;
        r_ol   <= n_ol;
    end

    assign o_pop          = w_pop;
    assign o_out.valid    = r_ov;
    assign o_out.out_byte = r_ob;
    assign o_out.last     = r_ol;

endmodule

// ----- hdl/morse_text_translator.sv -----
// An accepted byte's first result passes through the queue, the output
// sequencer's job registers and then the output register. Results leave at
// one per cycle while the output is ready, and a byte causes one to six
// results. A byte without results skips the sequencer, and bytes are taken
// every cycle while the queue has room. Reset is synchronous and active low:
// it clears the mode, the token state, the queue and the output valid flag.
module morse_text_translator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mtt_text_if.sink  i_in,
    mtt_sym_if.source o_out,
    mtt_cfg_if.sink   i_cfg
);

    logic          r_mode;
    logic          w_push;
    logic          w_pop;
    logic          w_empty;
    logic          w_full;
    mtt_pkg::t_job w_job_in;
    mtt_pkg::t_job w_job_out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg.valid) begin
            r_mode <= i_cfg.mode;
        end
    end

    mtt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_full  (w_full),
        .i_in    (i_in),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    mtt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_empty (w_empty),
        .o_full  (w_full)
    );

    mtt_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_job   (w_job_out),
        .i_empty (w_empty),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("Job queue written while full.");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("Job queue read while empty.");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out.valid)
        else $error("Output valid right after reset.");

    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.ready |=> r_mode == $past(i_cfg.mode))
        else $error("Mode register did not take the written value.");
`endif

endmodule
